@@ rtl/bbe_pkg.sv @@
// Types, codes and helper functions shared by the blitter engine files.
package bbe_pkg;

    localparam int PatternLines = 16;

    // Input transaction kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_PAT   = 2'd2;

    // Result access codes
    localparam logic [2:0] ACC_RD_SRC = 3'd0;
    localparam logic [2:0] ACC_RD_DST = 3'd1;
    localparam logic [2:0] ACC_WR_DST = 3'd2;
    localparam logic [2:0] ACC_FINISH = 3'd3;
    localparam logic [2:0] ACC_IDLE   = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_SRC_X  = 3'd0;
    localparam logic [2:0] REG_SRC_Y  = 3'd1;
    localparam logic [2:0] REG_DST_X  = 3'd2;
    localparam logic [2:0] REG_DST_Y  = 3'd3;
    localparam logic [2:0] REG_MASKS  = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;

    // Logic op uses halftone / destination, bit i for op i
    localparam logic [15:0] OP_USES_HOP = 16'h7BDE;
    localparam logic [15:0] OP_USES_DST = 16'h6FF6;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_XFETCH = 5'b00010,
        PH_SREAD  = 5'b00100,
        PH_DREAD  = 5'b01000,
        PH_WRITE  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [15:0] src_x;
        logic [15:0] src_y;
        logic [15:0] dst_x;
        logic [15:0] dst_y;
        logic [47:0] masks;
        logic [16:0] mode;
    } t_cfg;

    typedef struct packed {
        logic [31:0] shift_buf;
        logic [15:0] last_word;
        logic [15:0] dest_word;
        logic [15:0] words_left;
        logic [15:0] line_reload;
        logic [16:0] lines_rem;
        logic [3:0]  pat_line;
        logic        xfetch_done;
        logic        skip_fetch;
        logic        src_taken;
        logic        busy;
        t_phase      phase;
    } t_state;

    typedef struct packed {
        logic [2:0]  access;
        logic [23:0] address;
        logic [15:0] data;
        logic [16:0] lines;
    } t_result;

    function automatic logic [31:0] f_shift_in(input logic [31:0] sb, input logic [15:0] w,
                                               input logic neg);
        if (neg) begin
            return {w, sb[31:16]};
        end
        return {sb[15:0], w};
    endfunction

    function automatic logic [15:0] f_logic(input logic [3:0] op, input logic [15:0] h,
                                            input logic [15:0] d);
        logic [15:0] r;
        unique case (op)
            4'd0:    r = 16'h0000;
            4'd1:    r = h & d;
            4'd2:    r = h & ~d;
            4'd3:    r = h;
            4'd4:    r = ~h & d;
            4'd5:    r = d;
            4'd6:    r = h ^ d;
            4'd7:    r = h | d;
            4'd8:    r = ~h & ~d;
            4'd9:    r = ~(h ^ d);
            4'd10:   r = ~d;
            4'd11:   r = h | ~d;
            4'd12:   r = ~h;
            4'd13:   r = ~h | d;
            4'd14:   r = ~h | ~d;
            default: r = 16'hFFFF;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/bbe_regs.sv @@
// APB configuration register file of the blitter engine.
module bbe_regs import bbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_en;
    logic [2:0] idx;

    assign idx    = paddr[5:3];
    assign w_en   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_en) begin
            unique case (idx)
                REG_SRC_X: r_cfg.src_x <= pwdata[15:0];
                REG_SRC_Y: r_cfg.src_y <= pwdata[15:0];
                REG_DST_X: r_cfg.dst_x <= pwdata[15:0];
                REG_DST_Y: r_cfg.dst_y <= pwdata[15:0];
                REG_MASKS: r_cfg.masks <= pwdata[47:0];
                REG_MODE:  r_cfg.mode  <= pwdata[16:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SRC_X: prdata = {48'd0, r_cfg.src_x};
            REG_SRC_Y: prdata = {48'd0, r_cfg.src_y};
            REG_DST_X: prdata = {48'd0, r_cfg.dst_x};
            REG_DST_Y: prdata = {48'd0, r_cfg.dst_y};
            REG_MASKS: prdata = {16'd0, r_cfg.masks};
            REG_MODE:  prdata = {47'd0, r_cfg.mode};
            default:   prdata = 64'd0;
        endcase
    end

endmodule

@@ rtl/bbe_core.sv @@
// Next-state and bus request logic for one transaction of the blitter engine.
module bbe_core import bbe_pkg::*; #(
    parameter int ADDRESS_BITS = 24
) (
    input  t_cfg                    i_cfg,
    input  t_state                  i_st,
    input  logic [ADDRESS_BITS-1:0] i_src_ptr,
    input  logic [ADDRESS_BITS-1:0] i_dst_ptr,
    input  logic [15:0]             i_pat_ram [PatternLines],
    input  logic [1:0]              i_kind,
    input  logic [23:0]             i_source_start,
    input  logic [23:0]             i_dest_start,
    input  logic [15:0]             i_words_per_line,
    input  logic [15:0]             i_line_count,
    input  logic [15:0]             i_read_data,
    output t_state                  o_st,
    output logic [ADDRESS_BITS-1:0] o_src_ptr,
    output logic [ADDRESS_BITS-1:0] o_dst_ptr,
    output t_result                 o_res
);

    localparam logic [ADDRESS_BITS-1:0] AddrMask = {{(ADDRESS_BITS-1){1'b1}}, 1'b0};

    function automatic logic [ADDRESS_BITS-1:0] f_step(input logic [15:0] r);
        return {{(ADDRESS_BITS-16){r[15]}}, r[15:1], 1'b0};
    endfunction

    always_comb begin
        t_state n;
        logic [ADDRESS_BITS-1:0] sp, dp;
        logic do_issue;
        t_phase from;
        logic [1:0] hop;
        logic [3:0] lop;
        logic smudge, nfsr, fxsr, first, need_src, need_dst;
        logic [15:0] mask, h, pat, res;
        logic [31:0] skw;
        logic [2:0] acc;
        logic [ADDRESS_BITS-1:0] addr;
        logic [15:0] wdata;

        n        = i_st;
        sp       = i_src_ptr;
        dp       = i_dst_ptr;
        do_issue = 1'b0;
        from     = PH_XFETCH;
        hop      = i_cfg.mode[1:0];
        lop      = i_cfg.mode[5:2];
        smudge   = i_cfg.mode[6];
        nfsr     = i_cfg.mode[11];
        fxsr     = i_cfg.mode[12];
        acc      = ACC_IDLE;
        addr     = '0;
        wdata    = '0;
        first    = 1'b0;
        mask     = '0;
        need_src = 1'b0;
        need_dst = 1'b0;
        h        = '0;
        pat      = '0;
        res      = '0;
        skw      = '0;

        unique case (i_kind)
            KIND_START: begin
                if (!i_st.busy) begin
                    sp            = {{(ADDRESS_BITS-24){1'b0}}, i_source_start} & AddrMask;
                    dp            = {{(ADDRESS_BITS-24){1'b0}}, i_dest_start} & AddrMask;
                    n.line_reload = i_words_per_line;
                    n.words_left  = i_words_per_line;
                    n.lines_rem   = (i_line_count == 16'd0) ? 17'h10000
                                                            : {1'b0, i_line_count};
                    n.pat_line    = i_cfg.mode[16:13];
                    n.xfetch_done = 1'b0;
                    n.skip_fetch  = 1'b0;
                    n.src_taken   = 1'b0;
                    n.busy        = 1'b1;
                    do_issue      = 1'b1;
                end
            end
            KIND_DONE: begin
                if (i_st.busy) begin
                    do_issue = 1'b1;
                    unique case (i_st.phase)
                        PH_XFETCH: begin
                            n.shift_buf   = f_shift_in(n.shift_buf, i_read_data,
                                                       i_cfg.src_x[15]);
                            n.last_word   = i_read_data;
                            sp            = (sp + f_step(i_cfg.src_x)) & AddrMask;
                            n.xfetch_done = 1'b1;
                            from          = PH_SREAD;
                        end
                        PH_SREAD: begin
                            n.shift_buf = f_shift_in(n.shift_buf, i_read_data,
                                                     i_cfg.src_x[15]);
                            n.last_word = i_read_data;
                            n.src_taken = 1'b1;
                            from        = PH_DREAD;
                        end
                        PH_DREAD: begin
                            n.dest_word = i_read_data;
                            n.last_word = i_read_data;
                            from        = PH_WRITE;
                        end
                        PH_WRITE: begin
                            // word written: step pointers and counters
                            if (nfsr && n.words_left == 16'd1) begin
                                n.shift_buf = f_shift_in(n.shift_buf, n.last_word,
                                                         i_cfg.src_x[15]);
                            end
                            if (n.words_left == 16'd2 && nfsr) begin
                                n.skip_fetch = 1'b1;
                            end
                            if (n.src_taken) begin
                                sp = (sp + ((n.words_left == 16'd1 || n.skip_fetch)
                                            ? f_step(i_cfg.src_y)
                                            : f_step(i_cfg.src_x))) & AddrMask;
                            end
                            if (n.words_left == 16'd1) begin
                                n.xfetch_done = 1'b0;
                                n.lines_rem   = n.lines_rem - 17'd1;
                                n.words_left  = n.line_reload;
                                dp            = (dp + f_step(i_cfg.dst_y)) & AddrMask;
                                n.pat_line    = i_cfg.dst_y[15] ? n.pat_line - 4'd1
                                                                : n.pat_line + 4'd1;
                            end else begin
                                n.words_left = n.words_left - 16'd1;
                                dp           = (dp + f_step(i_cfg.dst_x)) & AddrMask;
                            end
                            n.src_taken = 1'b0;
                            if (n.lines_rem == 17'd0) begin
                                n.busy   = 1'b0;
                                n.phase  = PH_IDLE;
                                acc      = ACC_FINISH;
                                do_issue = 1'b0;
                            end
                        end
                        default: from = PH_XFETCH;
                    endcase
                end
            end
            default: ;
        endcase

        if (do_issue) begin
            first = (n.words_left == n.line_reload);
            if (first || n.line_reload == 16'd1) begin
                mask = i_cfg.masks[15:0];
            end else if (n.words_left == 16'd1) begin
                mask = i_cfg.masks[47:32];
            end else begin
                mask = i_cfg.masks[31:16];
            end
            if (first) begin
                n.skip_fetch = 1'b0;
            end
            need_src = OP_USES_HOP[lop] && (hop[1] || (hop == 2'd1 && smudge));
            need_dst = OP_USES_DST[lop] || (mask != 16'hFFFF);
            if (from == PH_XFETCH && first && fxsr && need_src && !n.xfetch_done) begin
                n.phase = PH_XFETCH;
                acc     = ACC_RD_SRC;
                addr    = sp;
            end else if ((from == PH_XFETCH || from == PH_SREAD) && need_src
                         && !n.skip_fetch) begin
                n.phase = PH_SREAD;
                acc     = ACC_RD_SRC;
                addr    = sp;
            end else if (from != PH_WRITE && need_dst) begin
                n.phase = PH_DREAD;
                acc     = ACC_RD_DST;
                addr    = dp;
            end else begin
                if (nfsr && n.words_left == 16'd1) begin
                    n.shift_buf = f_shift_in(n.shift_buf, n.last_word, i_cfg.src_x[15]);
                end
                skw = n.shift_buf >> i_cfg.mode[10:7];
                pat = smudge ? i_pat_ram[skw[3:0]] : i_pat_ram[n.pat_line];
                unique case (hop)
                    2'd0:    h = 16'hFFFF;
                    2'd1:    h = pat;
                    2'd2:    h = skw[15:0];
                    default: h = skw[15:0] & pat;
                endcase
                res = f_logic(lop, h, n.dest_word);
                if (mask != 16'hFFFF) begin
                    res = (res & mask) | (n.dest_word & ~mask);
                end
                n.last_word = res;
                n.phase     = PH_WRITE;
                acc         = ACC_WR_DST;
                addr        = dp;
                wdata       = res;
            end
        end

        o_st          = n;
        o_src_ptr     = sp;
        o_dst_ptr     = dp;
        o_res.access  = acc;
        o_res.address = addr[23:0] & 24'hFFFFFE;
        o_res.data    = wdata;
        o_res.lines   = n.lines_rem;
    end

endmodule

@@ rtl/bitplane_blitter_engine.sv @@
// Top level of the bit-block transfer engine: state, halftone RAM and result register.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+---------------------------------------------
//  input    | i_in_valid  | o_in_ready  | i_kind, i_source_start, i_dest_start, ...
//  result   | o_out_valid | i_out_ready | o_access, o_bus_address, o_write_data, ...
//  config   | psel/penable| pready (=1) | paddr, pwdata, prdata (register i at 8*i)
//
// Each input transaction is worked combinationally; its result is in the output
// register the next cycle. One transaction per cycle is sustained while the result
// side takes them; a stalled result holds and blocks new input only while it waits.
// Synchronous active-low reset clears all state and the halftone RAM, but not r_res.
module bitplane_blitter_engine import bbe_pkg::*; #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [23:0] i_source_start,
    input  logic [23:0] i_dest_start,
    input  logic [15:0] i_words_per_line,
    input  logic [15:0] i_line_count,
    input  logic [15:0] i_read_data,
    input  logic [3:0]  i_pattern_index,
    input  logic [15:0] i_pattern_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_access,
    output logic [23:0] o_bus_address,
    output logic [15:0] o_write_data,
    output logic [16:0] o_lines_left,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg                    cfg;
    t_state                  r_st, n_st;
    logic [ADDRESS_BITS-1:0] r_src_ptr, n_src_ptr, r_dst_ptr, n_dst_ptr;
    logic [15:0]             r_pat_ram [PatternLines];
    t_result                 r_res, n_res;
    logic                    r_out_valid;
    logic                    in_acc;

    bbe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bbe_core #(.ADDRESS_BITS(ADDRESS_BITS)) u_core (
        .i_cfg            (cfg),
        .i_st             (r_st),
        .i_src_ptr        (r_src_ptr),
        .i_dst_ptr        (r_dst_ptr),
        .i_pat_ram        (r_pat_ram),
        .i_kind           (i_kind),
        .i_source_start   (i_source_start),
        .i_dest_start     (i_dest_start),
        .i_words_per_line (i_words_per_line),
        .i_line_count     (i_line_count),
        .i_read_data      (i_read_data),
        .o_st             (n_st),
        .o_src_ptr        (n_src_ptr),
        .o_dst_ptr        (n_dst_ptr),
        .o_res            (n_res)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '{phase: PH_IDLE, default: '0};
            r_src_ptr   <= '0;
            r_dst_ptr   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PatternLines; i++) begin
                r_pat_ram[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_st      <= n_st;
                r_src_ptr <= n_src_ptr;
                r_dst_ptr <= n_dst_ptr;
                if (i_kind == KIND_PAT) begin
                    r_pat_ram[i_pattern_index] <= i_pattern_word;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_access      = r_res.access;
    assign o_bus_address = r_res.address;
    assign o_write_data  = r_res.data;
    assign o_lines_left  = r_res.lines;

endmodule

@@ rtl/bbe_checker.sv @@
// Port-level checks of the blitter engine, bound to the top level.
module bbe_checker import bbe_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_access,
    input logic [23:0] o_bus_address,
    input logic [15:0] o_write_data,
    input logic [16:0] o_lines_left
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_access)
            && $stable(o_bus_address) && $stable(o_write_data))
        else $error("stalled result changed");

    a_finish_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_access == ACC_FINISH |-> o_lines_left == 17'd0)
        else $error("finish with lines left");

    a_data_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_access != ACC_WR_DST |-> o_write_data == 16'd0)
        else $error("write data outside a write");

    a_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_access == ACC_FINISH || o_access == ACC_IDLE)
            |-> o_bus_address == 24'd0)
        else $error("address on a non-bus result");

    a_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_bus_address[0])
        else $error("odd bus address");

endmodule

bind bitplane_blitter_engine bbe_checker u_bbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_access      (o_access),
    .o_bus_address (o_bus_address),
    .o_write_data  (o_write_data),
    .o_lines_left  (o_lines_left)
);
